FILE: design/rwrb_pkg.sv
// Shared types and constants for the receive window reorder buffer.
package rwrb_pkg;

  localparam int DEFAULT_WINDOW_DEPTH  = 16;
  localparam int DEFAULT_PAYLOAD_WIDTH = 64;

  localparam int ID_WIDTH     = 32;
  localparam int ACTION_WIDTH = 2;
  localparam int STATUS_WIDTH = 2;
  localparam int OCC_WIDTH    = 5;

  localparam logic [ACTION_WIDTH-1:0] ACT_PUSH  = 2'd0;
  localparam logic [ACTION_WIDTH-1:0] ACT_POP   = 2'd1;
  localparam logic [ACTION_WIDTH-1:0] ACT_CLEAR = 2'd2;

  localparam logic [STATUS_WIDTH-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_FULL   = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_OLD    = 2'd2;
  localparam logic [STATUS_WIDTH-1:0] ST_BEYOND = 2'd3;

  typedef struct packed {
    logic accept;
    logic fill_payload;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pop_hit;
  } dp_status_t;

endpackage

FILE: design/rwrb_if.sv
// Valid/ready channel interfaces for request and result words.
interface rwrb_in_if #(
  parameter int PAYLOAD_WIDTH = rwrb_pkg::DEFAULT_PAYLOAD_WIDTH
);
  logic                                valid;
  logic                                ready;
  logic [rwrb_pkg::ACTION_WIDTH-1:0]   action;
  logic [rwrb_pkg::ID_WIDTH-1:0]       packet_id;
  logic [PAYLOAD_WIDTH-1:0]            payload;

  modport source (output valid, action, packet_id, payload, input ready);
  modport sink   (input valid, action, packet_id, payload, output ready);
endinterface

interface rwrb_out_if #(
  parameter int PAYLOAD_WIDTH = rwrb_pkg::DEFAULT_PAYLOAD_WIDTH
);
  logic                                valid;
  logic                                ready;
  logic [rwrb_pkg::STATUS_WIDTH-1:0]   status;
  logic                                out_valid;
  logic [rwrb_pkg::ID_WIDTH-1:0]       out_id;
  logic [PAYLOAD_WIDTH-1:0]            out_payload;
  logic [rwrb_pkg::OCC_WIDTH-1:0]      occupancy;
  logic                                window_empty;
  logic [rwrb_pkg::ID_WIDTH-1:0]       window_low;

  modport source (output valid, status, out_valid, out_id, out_payload, occupancy,
                  window_empty, window_low, input ready);
  modport sink   (input valid, status, out_valid, out_id, out_payload, occupancy,
                  window_empty, window_low, output ready);
endinterface

FILE: design/rwrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rwrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: design/rwrb_ctrl.sv
// Handshake controller: accepts words, waits on the payload read, holds the result.
module rwrb_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  rwrb_pkg::dp_status_t status,
  output rwrb_pkg::ctrl_cmd_t  cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state;
  logic state_next;
  logic out_full;
  logic out_full_next;
  logic accept;

  assign in_ready  = (state == S_IDLE) && (!out_full || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_full;

  assign cmd.accept       = accept;
  assign cmd.fill_payload = (state == S_READ);

  always_comb begin
    state_next    = state;
    out_full_next = out_full;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (status.pop_hit) begin
            state_next    = S_READ;
            out_full_next = 1'b0;
          end else begin
            out_full_next = 1'b1;
          end
        end else if (out_ready) begin
          out_full_next = 1'b0;
        end
      end
      S_READ: begin
        state_next    = S_IDLE;
        out_full_next = 1'b1;
      end
      default: begin
        state_next    = S_IDLE;
        out_full_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

endmodule

FILE: design/rwrb_dp.sv
// Datapath: window state, slot flags, payload RAM and result register.
module rwrb_dp #(
  parameter int WINDOW_DEPTH  = rwrb_pkg::DEFAULT_WINDOW_DEPTH,
  parameter int PAYLOAD_WIDTH = rwrb_pkg::DEFAULT_PAYLOAD_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  rwrb_pkg::ctrl_cmd_t                cmd,
  output rwrb_pkg::dp_status_t               status,
  input  logic [rwrb_pkg::ACTION_WIDTH-1:0]  action,
  input  logic [rwrb_pkg::ID_WIDTH-1:0]      packet_id,
  input  logic [PAYLOAD_WIDTH-1:0]           payload,
  output logic [rwrb_pkg::STATUS_WIDTH-1:0]  res_status,
  output logic                               res_valid,
  output logic [rwrb_pkg::ID_WIDTH-1:0]      res_id,
  output logic [PAYLOAD_WIDTH-1:0]           res_payload,
  output logic [rwrb_pkg::OCC_WIDTH-1:0]     res_occupancy,
  output logic                               res_empty,
  output logic [rwrb_pkg::ID_WIDTH-1:0]      res_low
);

  localparam int IDW   = rwrb_pkg::ID_WIDTH;
  localparam int OCCW  = rwrb_pkg::OCC_WIDTH;
  localparam int IDX_W = $clog2(WINDOW_DEPTH);
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam logic [IDW-1:0]   SPAN     = IDW'(WINDOW_DEPTH - 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_DEPTH - 1);
  localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W + 1)'(WINDOW_DEPTH);
  localparam logic [IDW-1:0]   ID_MAX   = {IDW{1'b1}};

  logic [WINDOW_DEPTH-1:0] slot_full;
  logic [WINDOW_DEPTH-1:0] slot_full_next;
  logic [IDX_W-1:0]        head_slot;
  logic [IDX_W-1:0]        head_slot_next;
  logic [IDX_W-1:0]        low_mod;
  logic [IDX_W-1:0]        low_mod_next;
  logic [IDW-1:0]          lower_bound;
  logic [IDW-1:0]          lower_bound_next;
  logic [CNT_W-1:0]        full_count;
  logic [CNT_W-1:0]        full_count_next;

  logic [IDW-1:0]          offset;
  logic [IDX_W:0]          idx_sum;
  logic [IDX_W-1:0]        push_idx;
  logic                    head_full;
  logic                    push_ok;
  logic [rwrb_pkg::STATUS_WIDTH-1:0] status_next;
  logic [PAYLOAD_WIDTH-1:0] ram_rd_data;

  // Slot of an in-window id is (lower_bound mod depth + offset) mod depth.
  assign offset    = packet_id - lower_bound;
  assign idx_sum   = {1'b0, low_mod} + {1'b0, offset[IDX_W-1:0]};
  assign push_idx  = (idx_sum >= DEPTH_X) ? IDX_W'(idx_sum - DEPTH_X) : idx_sum[IDX_W-1:0];
  assign head_full = slot_full[head_slot];

  assign status.pop_hit = (action == rwrb_pkg::ACT_POP) && head_full;

  always_comb begin
    slot_full_next   = slot_full;
    head_slot_next   = head_slot;
    low_mod_next     = low_mod;
    lower_bound_next = lower_bound;
    full_count_next  = full_count;
    status_next      = rwrb_pkg::ST_OK;
    push_ok          = 1'b0;
    case (action)
      rwrb_pkg::ACT_PUSH: begin
        if (packet_id < lower_bound) begin
          status_next = rwrb_pkg::ST_OLD;
        end else if (offset > SPAN) begin
          status_next = rwrb_pkg::ST_BEYOND;
        end else if (slot_full[push_idx]) begin
          status_next = rwrb_pkg::ST_FULL;
        end else begin
          push_ok                  = 1'b1;
          slot_full_next[push_idx] = 1'b1;
          full_count_next          = full_count + CNT_W'(1);
        end
      end
      rwrb_pkg::ACT_POP: begin
        if (head_full) begin
          slot_full_next[head_slot] = 1'b0;
          full_count_next           = full_count - CNT_W'(1);
          head_slot_next   = (head_slot == LAST_IDX) ? '0 : head_slot + IDX_W'(1);
          lower_bound_next = lower_bound + IDW'(1);
          if (lower_bound == ID_MAX) begin
            low_mod_next = '0;
          end else begin
            low_mod_next = (low_mod == LAST_IDX) ? '0 : low_mod + IDX_W'(1);
          end
        end
      end
      rwrb_pkg::ACT_CLEAR: begin
        slot_full_next  = '0;
        full_count_next = '0;
      end
      default: begin
      end
    endcase
  end

  rwrb_ram #(
    .WIDTH (PAYLOAD_WIDTH),
    .DEPTH (WINDOW_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.accept && push_ok),
    .wr_addr (push_idx),
    .wr_data (payload),
    .rd_en   (cmd.accept && status.pop_hit),
    .rd_addr (head_slot),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_full   <= '0;
      head_slot   <= '0;
      low_mod     <= '0;
      lower_bound <= '0;
      full_count  <= '0;
    end else if (cmd.accept) begin
      slot_full   <= slot_full_next;
      head_slot   <= head_slot_next;
      low_mod     <= low_mod_next;
      lower_bound <= lower_bound_next;
      full_count  <= full_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_status    <= status_next;
      res_valid     <= status.pop_hit;
      res_id        <= status.pop_hit ? lower_bound : '0;
      res_payload   <= '0;
      res_occupancy <= OCCW'(full_count_next);
      res_empty     <= (full_count_next == '0);
      res_low       <= lower_bound_next;
    end else if (cmd.fill_payload) begin
      res_payload   <= ram_rd_data;
    end
  end

endmodule

FILE: design/receive_window_reorder_buffer.sv
// Top level of the receive window reorder buffer.
// The result word is registered when the request word is accepted; a pop that returns
// a packet also waits on the registered payload RAM read before its result is offered.
// Throughput: one word per cycle while results are taken; a returning pop
// holds the input while its payload is read.
// Reset clears slot flags, count and window bound; payload RAM is not cleared.
module receive_window_reorder_buffer #(
  parameter int WINDOW_DEPTH  = rwrb_pkg::DEFAULT_WINDOW_DEPTH,
  parameter int PAYLOAD_WIDTH = rwrb_pkg::DEFAULT_PAYLOAD_WIDTH
) (
  input  logic      clk,
  input  logic      rst,
  rwrb_in_if.sink   ingress,
  rwrb_out_if.source egress
);

  rwrb_pkg::ctrl_cmd_t  cmd;
  rwrb_pkg::dp_status_t dp_status;

  rwrb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ingress.valid),
    .in_ready  (ingress.ready),
    .out_valid (egress.valid),
    .out_ready (egress.ready),
    .status    (dp_status),
    .cmd       (cmd)
  );

  rwrb_dp #(
    .WINDOW_DEPTH  (WINDOW_DEPTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (dp_status),
    .action        (ingress.action),
    .packet_id     (ingress.packet_id),
    .payload       (ingress.payload),
    .res_status    (egress.status),
    .res_valid     (egress.out_valid),
    .res_id        (egress.out_id),
    .res_payload   (egress.out_payload),
    .res_occupancy (egress.occupancy),
    .res_empty     (egress.window_empty),
    .res_low       (egress.window_low)
  );

endmodule

FILE: design/rwrb_checker.sv
// Port-level checks on result words of the reorder buffer, bound to the top level.
module rwrb_checker #(
  parameter int PAYLOAD_WIDTH = rwrb_pkg::DEFAULT_PAYLOAD_WIDTH
) (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_word_valid,
  input logic                              out_word_ready,
  input logic [rwrb_pkg::STATUS_WIDTH-1:0] status,
  input logic                              out_valid,
  input logic [rwrb_pkg::ID_WIDTH-1:0]     out_id,
  input logic [PAYLOAD_WIDTH-1:0]          out_payload,
  input logic [rwrb_pkg::OCC_WIDTH-1:0]    occupancy,
  input logic                              window_empty,
  input logic [rwrb_pkg::ID_WIDTH-1:0]     window_low
);

  localparam int IDW = rwrb_pkg::ID_WIDTH;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_word_valid && !out_word_ready |=> out_word_valid)
    else $error("result word dropped while stalled");

  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    out_word_valid && window_empty |-> occupancy == '0)
    else $error("empty window with nonzero occupancy");

  a_pop_status: assert property (@(posedge clk) disable iff (rst)
    out_word_valid && out_valid |-> status == rwrb_pkg::ST_OK)
    else $error("returned packet with error status");

  a_pop_slide: assert property (@(posedge clk) disable iff (rst)
    out_word_valid && out_valid |-> IDW'(out_id + IDW'(1)) == window_low)
    else $error("window did not slide past returned packet");

  a_no_packet: assert property (@(posedge clk) disable iff (rst)
    out_word_valid && !out_valid |-> out_id == '0 && out_payload == '0)
    else $error("packet fields set without a returned packet");

endmodule

bind receive_window_reorder_buffer rwrb_checker #(
  .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
) u_rwrb_checker (
  .clk            (clk),
  .rst            (rst),
  .out_word_valid (egress.valid),
  .out_word_ready (egress.ready),
  .status         (egress.status),
  .out_valid      (egress.out_valid),
  .out_id         (egress.out_id),
  .out_payload    (egress.out_payload),
  .occupancy      (egress.occupancy),
  .window_empty   (egress.window_empty),
  .window_low     (egress.window_low)
);

FILE: sim/receive_window_reorder_buffer_tb.sv
// Testbench for the receive window reorder buffer: random and directed words, checked in order.
module receive_window_reorder_buffer_tb;
  import rwrb_pkg::*;

  localparam int DEPTH = DEFAULT_WINDOW_DEPTH;
  localparam int PW    = DEFAULT_PAYLOAD_WIDTH;
  localparam int HW    = $clog2(DEPTH);
  localparam logic [ACTION_WIDTH-1:0] ACT_UNUSED = 2'd3;
  localparam int DIRECTED_WORDS = 16;
  localparam int RANDOM_WORDS   = 1250;
  localparam int LONG_HOLD      = 90;
  localparam int MAX_REPORTS    = 50;

  typedef struct packed {
    logic [ACTION_WIDTH-1:0] action;
    logic [ID_WIDTH-1:0]     packet_id;
    logic [PW-1:0]           payload;
    logic [7:0]              gap;
  } request_t;

  typedef struct packed {
    logic [STATUS_WIDTH-1:0] status;
    logic                    hit;
    logic [ID_WIDTH-1:0]     id;
    logic [PW-1:0]           data;
    logic [OCC_WIDTH-1:0]    occ;
    logic                    empty;
    logic [ID_WIDTH-1:0]     low;
  } reply_t;

  typedef struct packed {
    logic [DEPTH-1:0]         full;
    logic [DEPTH-1:0][PW-1:0] data;
    logic [HW-1:0]            head;
    logic [ID_WIDTH-1:0]      low;
    logic [15:0]              count;
  } window_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                    in_valid  = 1'b0;
  logic [ACTION_WIDTH-1:0] in_action = ACT_PUSH;
  logic [ID_WIDTH-1:0]     in_id     = '0;
  logic [PW-1:0]           in_data   = '0;
  logic                    out_ready = 1'b0;

  rwrb_in_if  #(.PAYLOAD_WIDTH(PW)) ingress ();
  rwrb_out_if #(.PAYLOAD_WIDTH(PW)) egress ();

  assign ingress.valid     = in_valid;
  assign ingress.action    = in_action;
  assign ingress.packet_id = in_id;
  assign ingress.payload   = in_data;
  assign egress.ready      = out_ready;

  receive_window_reorder_buffer #(
    .WINDOW_DEPTH (DEPTH),
    .PAYLOAD_WIDTH(PW)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .ingress(ingress),
    .egress (egress)
  );

  window_t  model_st = '0;
  window_t  gen_st   = '0;
  request_t pending_words[$];
  reply_t   expected_replies[$];
  int       words_built = 0;
  int       errors      = 0;

  int words_sent      = 0;
  int packets_popped  = 0;
  int empty_pops      = 0;
  int pushes_refused  = 0;
  int clears_done     = 0;
  int peak_occ        = 0;

  function automatic reply_t advance_window(inout window_t w, input request_t r);
    reply_t              rep;
    logic [ID_WIDTH:0]   top;
    logic [HW-1:0]       slot;
    rep  = '0;
    top  = {1'b0, w.low} + (DEPTH - 1);
    slot = HW'(r.packet_id % DEPTH);
    case (r.action)
      ACT_PUSH: begin
        if (r.packet_id < w.low) begin
          rep.status = ST_OLD;
        end else if ({1'b0, r.packet_id} > top) begin
          rep.status = ST_BEYOND;
        end else if (w.full[slot]) begin
          rep.status = ST_FULL;
        end else begin
          w.full[slot] = 1'b1;
          w.data[slot] = r.payload;
          w.count      = w.count + 1;
        end
      end
      ACT_POP: begin
        if (w.full[w.head]) begin
          rep.hit = 1'b1;
          rep.id  = w.low;
          rep.data = w.data[w.head];
          w.full[w.head] = 1'b0;
          w.count = w.count - 1;
          w.head  = (w.head == HW'(DEPTH - 1)) ? '0 : w.head + 1'b1;
          w.low   = w.low + 1;
        end
      end
      ACT_CLEAR: begin
        w.full  = '0;
        w.count = '0;
      end
      default: ;
    endcase
    rep.occ   = w.count[OCC_WIDTH-1:0];
    rep.empty = (w.count == 0);
    rep.low   = w.low;
    return rep;
  endfunction

  task automatic add_word(input logic [ACTION_WIDTH-1:0] act, input logic [ID_WIDTH-1:0] id,
                          input logic [PW-1:0] pl, input int gap);
    request_t r;
    reply_t   unused;
    r.action    = act;
    r.packet_id = id;
    r.payload   = pl;
    r.gap       = 8'(gap);
    unused = advance_window(gen_st, r);
    pending_words.push_back(r);
    words_built++;
  endtask

  function automatic logic [PW-1:0] rand_payload();
    return PW'({$urandom, $urandom});
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      if (errors < MAX_REPORTS)
        $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
      errors++;
    end
  endfunction

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
  end

  // word source
  request_t cur_word;
  reply_t   sent_reply;
  int       idle_count = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      idle_count = 0;
    end else begin
      if (in_valid && ingress.ready) begin
        sent_reply = advance_window(model_st, cur_word);
        expected_replies.push_back(sent_reply);
        words_sent++;
        if (sent_reply.hit) packets_popped++;
        if (cur_word.action == ACT_POP && !sent_reply.hit) empty_pops++;
        if (cur_word.action == ACT_PUSH && sent_reply.status != ST_OK) pushes_refused++;
        if (cur_word.action == ACT_CLEAR) clears_done++;
        if (int'(sent_reply.occ) > peak_occ) peak_occ = int'(sent_reply.occ);
      end
      if (!in_valid || ingress.ready) begin
        if (pending_words.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idle_count < int'(pending_words[0].gap)) begin
          idle_count++;
          in_valid <= 1'b0;
        end else begin
          cur_word   = pending_words.pop_front();
          idle_count = 0;
          in_valid  <= 1'b1;
          in_action <= cur_word.action;
          in_id     <= cur_word.packet_id;
          in_data   <= cur_word.payload;
        end
      end
    end
  end

  // result sink
  reply_t want;
  int     results_seen = 0;
  int     stall_left   = 0;
  int     hold_left    = 0;
  bit     stall_mode   = 1'b1;
  bit     rdy_next;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_ready && egress.valid) begin
        if (expected_replies.size() == 0) begin
          if (errors < MAX_REPORTS) $error("result word with no request outstanding");
          errors++;
        end else begin
          want = expected_replies.pop_front();
          check_field("status", 64'(want.status), 64'(egress.status));
          check_field("out_valid", 64'(want.hit), 64'(egress.out_valid));
          check_field("out_id", 64'(want.id), 64'(egress.out_id));
          check_field("out_payload", 64'(want.data), 64'(egress.out_payload));
          check_field("occupancy", 64'(want.occ), 64'(egress.occupancy));
          check_field("window_empty", 64'(want.empty), 64'(egress.window_empty));
          check_field("window_low", 64'(want.low), 64'(egress.window_low));
        end
        results_seen++;
        if (results_seen == 40 || results_seen == 700)
          hold_left = LONG_HOLD;
        else if (stall_mode)
          stall_left = $urandom_range(0, 6);
        if (results_seen % 150 == 0) stall_mode = !stall_mode;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy_next = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy_next = 1'b0;
      end else begin
        rdy_next = 1'b1;
      end
      out_ready <= rdy_next;
    end
  end

  // stimulus and end of run
  initial begin
    int ofs[DEPTH];
    int i, j, k, n, t, pick, pops;
    bit idle_on;
    logic [ID_WIDTH-1:0] base;

    // directed
    add_word(ACT_POP,    32'd0,          '0,            0);
    add_word(ACT_PUSH,   32'd0,          '1,            0);
    add_word(ACT_PUSH,   32'd0,          '0,            0);
    add_word(ACT_PUSH,   32'(DEPTH - 1), '0,            0);
    add_word(ACT_PUSH,   32'(DEPTH),     rand_payload(), 0);
    add_word(ACT_PUSH,   32'hFFFF_FFFF,  rand_payload(), 0);
    add_word(ACT_UNUSED, $urandom,       rand_payload(), 0);
    add_word(ACT_POP,    32'd0,          '0,            0);
    add_word(ACT_PUSH,   32'd0,          rand_payload(), 0);
    add_word(ACT_PUSH,   32'(DEPTH),     {(PW/8){8'hA5}}, 0);
    add_word(ACT_POP,    32'd0,          '0,            0);
    add_word(ACT_CLEAR,  32'd0,          '0,            0);
    add_word(ACT_POP,    32'd0,          '0,            0);
    add_word(ACT_PUSH,   32'd1,          {(PW/8){8'h55}}, 0);
    add_word(ACT_POP,    32'd0,          '0,            0);
    add_word(ACT_CLEAR,  $urandom,       rand_payload(), 0);

    // random: mostly in-window bursts followed by pops, some noise
    while (words_built < DIRECTED_WORDS + RANDOM_WORDS) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 7) begin
        for (i = 0; i < DEPTH; i++) ofs[i] = i;
        for (i = DEPTH - 1; i > 0; i--) begin
          j = $urandom_range(0, i);
          t = ofs[i];
          ofs[i] = ofs[j];
          ofs[j] = t;
        end
        k = $urandom_range(1, DEPTH);
        base = gen_st.low;
        for (i = 0; i < k; i++)
          add_word(ACT_PUSH, base + ofs[i], rand_payload(), idle_on ? $urandom_range(0, 6) : 0);
        if ($urandom_range(0, 3) == 0)
          add_word(ACT_PUSH, base + ofs[0], rand_payload(), idle_on ? $urandom_range(0, 6) : 0);
        pops = ($urandom_range(0, 2) == 0) ? $urandom_range(0, k) : k + $urandom_range(0, 2);
        for (i = 0; i < pops; i++)
          add_word(ACT_POP, $urandom, rand_payload(), idle_on ? $urandom_range(0, 6) : 0);
      end else begin
        n = $urandom_range(4, 12);
        for (i = 0; i < n; i++) begin
          pick = $urandom_range(0, 9);
          t = idle_on ? $urandom_range(0, 6) : 0;
          case (pick)
            0, 1, 2: add_word(ACT_PUSH, $urandom, rand_payload(), t);
            3: begin
              case ($urandom_range(0, 2))
                0:       add_word(ACT_PUSH, gen_st.low - 1, rand_payload(), t);
                1:       add_word(ACT_PUSH, gen_st.low + DEPTH, rand_payload(), t);
                default: add_word(ACT_PUSH, gen_st.low + DEPTH - 1, rand_payload(), t);
              endcase
            end
            4: add_word(ACT_POP, $urandom, rand_payload(), t);
            5: add_word(ACT_CLEAR, $urandom, rand_payload(), t);
            6: add_word(ACT_UNUSED, $urandom, rand_payload(), t);
            default: add_word(ACT_PUSH, gen_st.low + $urandom_range(0, DEPTH - 1),
                              rand_payload(), t);
          endcase
        end
      end
    end

    while (rst) @(negedge clk);
    while (pending_words.size() != 0 || in_valid) @(negedge clk);
    while (expected_replies.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("run: %0d words, %0d packets popped, %0d pops on an empty head, %0d clears",
             words_sent, packets_popped, empty_pops, clears_done);
    $display("run: %0d pushes refused, peak occupancy %0d of %0d, final window low %0d",
             pushes_refused, peak_occ, DEPTH, model_st.low);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
